### rtl/core/gsc_pkg.sv
// ----------------------------------------------------------------------------
// gsc_pkg
// Shared types and constants of the grid slot coverage checker.
// ----------------------------------------------------------------------------
package gsc_pkg;

  // Error codes, also the encoding of the result's error_code field
  typedef enum logic [2:0] {
    ERR_NONE  = 3'd0,
    ERR_SIZE  = 3'd1,
    ERR_CLASS = 3'd2,
    ERR_TRAY  = 3'd3,
    ERR_COORD = 3'd4,
    ERR_DUP   = 3'd5
  } err_e;

  // Configuration register indexes
  localparam logic REG_FULL_MODE  = 1'b0;
  localparam logic REG_COORD_BASE = 1'b1;

  localparam logic [7:0]  CLASS_MAX = 8'd2;
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;
  localparam logic [8:0]  SEEN_MAX  = 9'd511;

  localparam int unsigned IN_DATA_W  = 56;
  localparam int unsigned OUT_DATA_W = 16;

  // One frame result
  typedef struct packed {
    logic [8:0] rows_seen;
    logic       dup;
    err_e       err;
    logic       ok;
  } res_t;

endpackage

### rtl/core/gsc_row_check.sv
// ----------------------------------------------------------------------------
// gsc_row_check
// Per-row class, tray and coordinate checks and the linear slot address.
// ----------------------------------------------------------------------------
module gsc_row_check #(
  parameter int unsigned TRAY_COUNT = 4,
  parameter int unsigned TRAY_COLS  = 8,
  parameter int unsigned TRAY_ROWS  = 8,
  localparam int unsigned SLOT_TOTAL = TRAY_COUNT * TRAY_COLS * TRAY_ROWS,
  localparam int unsigned SLOT_W = (SLOT_TOTAL > 1) ? $clog2(SLOT_TOTAL) : 1
) (
  input  logic [15:0]        tray_i,
  input  logic [15:0]        col_i,
  input  logic [15:0]        row_i,
  input  logic [7:0]         cls_i,
  input  logic               base_i,
  output gsc_pkg::err_e      err_o,
  output logic [SLOT_W-1:0]  slot_o
);

  localparam int unsigned TRAY_W = (TRAY_COUNT > 1) ? $clog2(TRAY_COUNT) : 1;
  localparam int unsigned COL_W  = (TRAY_COLS > 1) ? $clog2(TRAY_COLS) : 1;
  localparam int unsigned ROW_W  = (TRAY_ROWS > 1) ? $clog2(TRAY_ROWS) : 1;

  logic [16:0]       base_ext;
  logic [15:0]       tray0;
  logic [15:0]       col0;
  logic [15:0]       row0;
  logic              tray_bad;
  logic              coord_bad;

  assign base_ext = {16'd0, base_i};
  assign tray_bad = (tray_i == 16'd0) || (tray_i > 16'(TRAY_COUNT));
  assign coord_bad = ({1'b0, col_i} < base_ext) ||
                     ({1'b0, col_i} >= base_ext + 17'(TRAY_COLS)) ||
                     ({1'b0, row_i} < base_ext) ||
                     ({1'b0, row_i} >= base_ext + 17'(TRAY_ROWS));

  assign tray0 = tray_i - 16'd1;
  assign col0  = col_i - base_ext[15:0];
  assign row0  = row_i - base_ext[15:0];

  // Constant multipliers only; result is below SLOT_TOTAL when all checks pass
  assign slot_o = SLOT_W'(tray0[TRAY_W-1:0]) * SLOT_W'(TRAY_COLS * TRAY_ROWS)
                + SLOT_W'(row0[ROW_W-1:0]) * SLOT_W'(TRAY_COLS)
                + SLOT_W'(col0[COL_W-1:0]);

  always_comb begin
    priority if (cls_i > gsc_pkg::CLASS_MAX) begin
      err_o = gsc_pkg::ERR_CLASS;
    end else if (tray_bad) begin
      err_o = gsc_pkg::ERR_TRAY;
    end else if (coord_bad) begin
      err_o = gsc_pkg::ERR_COORD;
    end else begin
      err_o = gsc_pkg::ERR_NONE;
    end
  end

endmodule

### rtl/core/gsc_frame.sv
// ----------------------------------------------------------------------------
// gsc_frame
// Slot bitmap, row count, first error and the frame result register.
// ----------------------------------------------------------------------------
module gsc_frame #(
  parameter int unsigned TRAY_COUNT = 4,
  parameter int unsigned TRAY_COLS  = 8,
  parameter int unsigned TRAY_ROWS  = 8,
  localparam int unsigned SLOT_TOTAL = TRAY_COUNT * TRAY_COLS * TRAY_ROWS,
  localparam int unsigned SLOT_W = (SLOT_TOTAL > 1) ? $clog2(SLOT_TOTAL) : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  logic               last_i,
  input  gsc_pkg::err_e      chk_err_i,
  input  logic [SLOT_W-1:0]  slot_i,
  input  logic               full_mode_i,
  input  logic               res_ready_i,
  output logic               res_valid_o,
  output gsc_pkg::res_t      res_o
);

  logic [SLOT_TOTAL-1:0] taken_q;
  logic [15:0]           cnt_q, cnt_d;
  gsc_pkg::err_e         first_err_q, first_err_d;
  gsc_pkg::err_e         row_err;
  gsc_pkg::err_e         final_err;
  logic                  size_bad;
  logic                  res_valid_q;
  gsc_pkg::res_t         res_q, res_d;

  assign cnt_d = (cnt_q == gsc_pkg::COUNT_MAX) ? cnt_q : cnt_q + 16'd1;

  always_comb begin
    priority if (chk_err_i != gsc_pkg::ERR_NONE) begin
      row_err = chk_err_i;
    end else if (taken_q[slot_i]) begin
      row_err = gsc_pkg::ERR_DUP;
    end else begin
      row_err = gsc_pkg::ERR_NONE;
    end
  end

  assign first_err_d = (first_err_q == gsc_pkg::ERR_NONE) ? row_err : first_err_q;

  // Size rule: exact total in full mode, below total in sparse mode
  assign size_bad = full_mode_i ? ({1'b0, cnt_d} != 17'(SLOT_TOTAL))
                                : ({1'b0, cnt_d} >= 17'(SLOT_TOTAL));
  assign final_err = size_bad ? gsc_pkg::ERR_SIZE : first_err_d;

  always_comb begin
    res_d.ok        = (final_err == gsc_pkg::ERR_NONE);
    res_d.err       = final_err;
    res_d.dup       = (final_err == gsc_pkg::ERR_DUP);
    res_d.rows_seen = (cnt_d > 16'(gsc_pkg::SEEN_MAX)) ? gsc_pkg::SEEN_MAX : cnt_d[8:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taken_q     <= '0;
      cnt_q       <= '0;
      first_err_q <= gsc_pkg::ERR_NONE;
      res_valid_q <= 1'b0;
    end else begin
      if (fire_i && last_i) begin
        taken_q     <= '0;
        cnt_q       <= '0;
        first_err_q <= gsc_pkg::ERR_NONE;
        res_valid_q <= 1'b1;
      end else begin
        if (fire_i) begin
          if (row_err == gsc_pkg::ERR_NONE) begin
            taken_q[slot_i] <= 1'b1;
          end
          cnt_q       <= cnt_d;
          first_err_q <= first_err_d;
        end
        if (res_ready_i) begin
          res_valid_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i && last_i) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

`ifndef SYNTHESIS
  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && last_i |=> res_valid_q)
    else $error("frame end did not raise a result");

  a_frame_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && last_i |=> (cnt_q == 16'd0) && (first_err_q == gsc_pkg::ERR_NONE))
    else $error("frame state not cleared after frame end");

  a_ok_matches_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> (res_q.ok == (res_q.err == gsc_pkg::ERR_NONE)) &&
                    (res_q.dup == (res_q.err == gsc_pkg::ERR_DUP)))
    else $error("result flags disagree with error code");

  a_rows_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> (res_q.rows_seen != 9'd0))
    else $error("result with zero rows");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && last_i |-> !res_valid_q || res_ready_i)
    else $error("pending result overwritten");
`endif

endmodule

### rtl/core/grid_slot_coverage_checker.sv
// ----------------------------------------------------------------------------
// grid_slot_coverage_checker
// Frame coverage check over a grid of tray slots, one row word per cycle.
// ----------------------------------------------------------------------------
// Each input word is one frame row (tray, column, row, class, last-row mark on
// tlast). Rows are taken at one per cycle with no gaps: a word sits in the
// input register while the row checks, the slot bitmap test-and-set and the
// row count update run, and on the last row of a frame the pass/fail result
// lands in the output register at the next edge, which raises m_axis_tvalid.
// The bitmap is held in flip-flops, one per slot, so it is tested and set in
// the same cycle and cleared all at once at frame end; no clearing pass is
// needed after reset or between frames. Input flow stops only while a finished
// result waits on m_axis_tready and the next last row is ready to replace it.
// Configuration (full-grid mode, coordinate base) is to be written through
// cfg_we_i only while the block is idle; the block does not enforce this.
// Both registers reset to 1.
// ----------------------------------------------------------------------------
module grid_slot_coverage_checker #(
  parameter int unsigned TRAY_COUNT = 4,
  parameter int unsigned TRAY_COLS  = 8,
  parameter int unsigned TRAY_ROWS  = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic        cfg_data_i,
  // row stream in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [15:0] tray_number, [31:16] column_number, [47:32] row_number,
  // [55:48] class_code
  input  logic [gsc_pkg::IN_DATA_W-1:0] s_axis_tdata,
  input  logic        s_axis_tlast,   // last_row
  // result stream out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] frame_ok, [3:1] error_code, [4] duplicate_found, [13:5] rows_seen,
  // [15:14] zero
  output logic [gsc_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  localparam int unsigned SLOT_TOTAL = TRAY_COUNT * TRAY_COLS * TRAY_ROWS;
  localparam int unsigned SLOT_W = (SLOT_TOTAL > 1) ? $clog2(SLOT_TOTAL) : 1;

  // config registers
  logic full_mode_q;
  logic coord_base_q;

  // input register
  logic        in_valid_q;
  logic [15:0] tray_q, col_q, row_q;
  logic [7:0]  cls_q;
  logic        last_q;

  logic              fire;
  logic              s_accept;
  gsc_pkg::err_e     chk_err;
  logic [SLOT_W-1:0] slot;
  logic              res_valid;
  gsc_pkg::res_t     res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_mode_q  <= 1'b1;
      coord_base_q <= 1'b1;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == gsc_pkg::REG_FULL_MODE) begin
        full_mode_q <= cfg_data_i;
      end else if (cfg_idx_i == gsc_pkg::REG_COORD_BASE) begin
        coord_base_q <= cfg_data_i;
      end
    end
  end

  // A non-last row always proceeds; a last row needs the result slot free
  // or draining this cycle.
  assign fire = in_valid_q && (!last_q || !res_valid || m_axis_tready);
  assign s_axis_tready = !in_valid_q || fire;
  assign s_accept = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_accept) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      tray_q <= s_axis_tdata[15:0];
      col_q  <= s_axis_tdata[31:16];
      row_q  <= s_axis_tdata[47:32];
      cls_q  <= s_axis_tdata[55:48];
      last_q <= s_axis_tlast;
    end
  end

  gsc_row_check #(
    .TRAY_COUNT (TRAY_COUNT),
    .TRAY_COLS  (TRAY_COLS),
    .TRAY_ROWS  (TRAY_ROWS)
  ) u_row_check (
    .tray_i (tray_q),
    .col_i  (col_q),
    .row_i  (row_q),
    .cls_i  (cls_q),
    .base_i (coord_base_q),
    .err_o  (chk_err),
    .slot_o (slot)
  );

  gsc_frame #(
    .TRAY_COUNT (TRAY_COUNT),
    .TRAY_COLS  (TRAY_COLS),
    .TRAY_ROWS  (TRAY_ROWS)
  ) u_frame (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .last_i      (last_q),
    .chk_err_i   (chk_err),
    .slot_i      (slot),
    .full_mode_i (full_mode_q),
    .res_ready_i (m_axis_tready),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign m_axis_tvalid = res_valid;
  assign m_axis_tdata  = {2'b00, res.rows_seen, res.dup, 3'(res.err), res.ok};

endmodule

### bench/grid_slot_coverage_checker_tb.sv
// ----------------------------------------------------------------------------
// grid_slot_coverage_checker_tb
// Self-checking bench for the grid slot coverage checker.
// ----------------------------------------------------------------------------
// Streams frames of grid rows into the block and scores every frame verdict
// against an in-bench model of the slot bitmap, row count and first-error
// logic. Directed rows hit the field extremes and each row error. Random
// traffic follows: sparse frames, full-grid permutations with injected faults,
// a frame long enough to saturate rows_seen, and a frame left open across a
// mode change. Both stream sides idle in random bursts, except at the end.
// ----------------------------------------------------------------------------
module grid_slot_coverage_checker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TRAY_COUNT   = 4;
  localparam int unsigned TRAY_COLS    = 8;
  localparam int unsigned TRAY_ROWS    = 8;
  localparam int unsigned SLOT_TOTAL   = TRAY_COUNT * TRAY_COLS * TRAY_ROWS;
  localparam int unsigned DRAIN_CYCLES = 8;     // settling wait after the bench queues drain
  localparam int unsigned QUIET_LIMIT  = 2000;  // cycles without any handshake
  localparam int unsigned MAX_REPORTS  = 10;

  // One frame row as it travels on the input stream
  typedef struct {
    logic [15:0] tray;
    logic [15:0] col;
    logic [15:0] row;
    logic [7:0]  cls;
    logic        last;
  } grid_row_t;

  // Predicted verdict, stamped with the cycle its last row was accepted
  typedef struct {
    gsc_pkg::res_t   res;
    longint unsigned stamp;
  } verdict_t;

  // How a row is spoiled
  typedef enum int unsigned {BAD_CLASS, BAD_TRAY, BAD_COORD, BAD_NOISE} row_fault_e;
  // What goes wrong in a full-grid frame, besides its length
  typedef enum int unsigned {FAULT_NONE, FAULT_DUP, FAULT_ROW} frame_fault_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = 1'b0;
  logic cfg_data_i = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  // [15:0] tray_number, [31:16] column_number, [47:32] row_number,
  // [55:48] class_code
  logic [gsc_pkg::IN_DATA_W-1:0] s_axis_tdata = '0;
  logic s_axis_tlast = 1'b0;  // last_row
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  // [0] frame_ok, [3:1] error_code, [4] duplicate_found, [13:5] rows_seen,
  // [15:14] zero
  logic [gsc_pkg::OUT_DATA_W-1:0] m_axis_tdata;

  grid_slot_coverage_checker #(
    .TRAY_COUNT(TRAY_COUNT),
    .TRAY_COLS (TRAY_COLS),
    .TRAY_ROWS (TRAY_ROWS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #5ns clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  grid_row_t       rows_to_send[$];    // filled by the sequence, drained by the driver
  verdict_t        frame_verdicts[$];  // verdicts still owed by the block
  grid_row_t       row_on_bus;
  int unsigned     queued_items = 0;
  int unsigned     idle_pct = 0;       // chance (percent) of starting an idle burst
  int unsigned     send_gap = 0;
  int unsigned     hold_left = 0;
  int unsigned     mismatch_count = 0;
  int unsigned     quiet_cycles = 0;
  longint unsigned cycle_no = 0;

  // Bench copy of the block: config registers and per-frame state
  logic          full_grid_on = 1'b1;
  logic          coord_base = 1'b1;
  logic          slot_map[SLOT_TOTAL];
  logic [15:0]   frame_rows = '0;
  gsc_pkg::err_e frame_err = gsc_pkg::ERR_NONE;

  initial begin
    foreach (slot_map[i]) slot_map[i] = 1'b0;
  end

  always @(posedge clk_i) cycle_no <= cycle_no + 1;

  // --------------------------------------------------------------------------
  // Verdict prediction
  // --------------------------------------------------------------------------
  // Row checks run in fixed order: class, tray, coordinate, duplicate.
  // Only a clean row claims its slot.
  function automatic gsc_pkg::err_e classify_row(grid_row_t r);
    int unsigned slot;
    if (r.cls > gsc_pkg::CLASS_MAX) return gsc_pkg::ERR_CLASS;
    if (r.tray < 1 || r.tray > TRAY_COUNT) return gsc_pkg::ERR_TRAY;
    if (r.col < coord_base || r.col >= coord_base + TRAY_COLS ||
        r.row < coord_base || r.row >= coord_base + TRAY_ROWS) return gsc_pkg::ERR_COORD;
    slot = (r.tray - 1) * TRAY_COLS * TRAY_ROWS + (r.row - coord_base) * TRAY_COLS +
           (r.col - coord_base);
    if (slot_map[slot]) return gsc_pkg::ERR_DUP;
    slot_map[slot] = 1'b1;
    return gsc_pkg::ERR_NONE;
  endfunction

  // Folds one accepted row into the frame; the last row yields a verdict
  function automatic void absorb_row(grid_row_t r);
    gsc_pkg::err_e e;
    logic          size_bad;
    verdict_t      v;
    if (frame_rows < gsc_pkg::COUNT_MAX) frame_rows++;
    e = classify_row(r);
    if (frame_err == gsc_pkg::ERR_NONE) frame_err = e;
    if (!r.last) return;
    // mode is sampled on the last row; a size fault outranks any row fault
    if (full_grid_on) size_bad = (frame_rows != SLOT_TOTAL);
    else size_bad = (frame_rows == 0 || frame_rows >= SLOT_TOTAL);
    e = size_bad ? gsc_pkg::ERR_SIZE : frame_err;
    v.res.ok = (e == gsc_pkg::ERR_NONE);
    v.res.err = e;
    v.res.dup = (e == gsc_pkg::ERR_DUP);
    v.res.rows_seen = (frame_rows > gsc_pkg::SEEN_MAX) ? gsc_pkg::SEEN_MAX : frame_rows[8:0];
    v.stamp = cycle_no;
    frame_verdicts.push_back(v);
    foreach (slot_map[i]) slot_map[i] = 1'b0;
    frame_rows = '0;
    frame_err = gsc_pkg::ERR_NONE;
  endfunction

  // --------------------------------------------------------------------------
  // Verdict checking
  // --------------------------------------------------------------------------
  // A verdict stamped in this very cycle is not yet owed, so the outcome does
  // not hinge on whether driver or monitor runs first at the edge.
  function automatic void score_verdict(logic [gsc_pkg::OUT_DATA_W-1:0] word);
    verdict_t      want;
    gsc_pkg::res_t got;
    got = gsc_pkg::res_t'(word[$bits(gsc_pkg::res_t)-1:0]);
    if (frame_verdicts.size() == 0 || frame_verdicts[0].stamp == cycle_no) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("[%0t] unexpected verdict word %h", $realtime, word);
      return;
    end
    want = frame_verdicts.pop_front();
    if (got.ok !== want.res.ok || got.err !== want.res.err || got.dup !== want.res.dup ||
        got.rows_seen !== want.res.rows_seen ||
        word[gsc_pkg::OUT_DATA_W-1:$bits(gsc_pkg::res_t)] !== '0) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display({"[%0t] verdict mismatch: exp ok=%0d err=%0d dup=%0d rows=%0d pad=0",
                  " | got ok=%0d err=%0d dup=%0d rows=%0d pad=%0d"},
                 $realtime, want.res.ok, want.res.err, want.res.dup, want.res.rows_seen,
                 got.ok, got.err, got.dup, got.rows_seen,
                 word[gsc_pkg::OUT_DATA_W-1:$bits(gsc_pkg::res_t)]);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Driver: presents queued rows, predicts on each accepted word
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      s_axis_tlast <= 1'b0;
      send_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) absorb_row(row_on_bus);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (rows_to_send.size() > 0) begin
          row_on_bus = rows_to_send.pop_front();
          s_axis_tdata <= {row_on_bus.cls, row_on_bus.row, row_on_bus.col, row_on_bus.tray};
          s_axis_tlast <= row_on_bus.last;
          s_axis_tvalid <= 1'b1;
          if (idle_pct != 0 && $urandom_range(99, 0) < idle_pct)
            send_gap = $urandom_range(16, 1);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: random backpressure, checks each accepted verdict word
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      hold_left = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) score_verdict(m_axis_tdata);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (idle_pct != 0 && $urandom_range(99, 0) < idle_pct)
          hold_left = $urandom_range(16, 1);
      end
    end
  end

  // Watchdog: any handshake on either side counts as progress
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus builders
  // --------------------------------------------------------------------------
  function automatic void add_row(int unsigned tray, int unsigned col, int unsigned row,
                                  int unsigned cls, logic last);
    grid_row_t r;
    r.tray = tray[15:0];
    r.col = col[15:0];
    r.row = row[15:0];
    r.cls = cls[7:0];
    r.last = last;
    rows_to_send.push_back(r);
    queued_items++;
  endfunction

  // Clean row aimed at a linear slot under the current coordinate base
  function automatic void add_slot_row(int unsigned slot, logic last);
    add_row(slot / (TRAY_COLS * TRAY_ROWS) + 1, slot % TRAY_COLS + coord_base,
            (slot / TRAY_COLS) % TRAY_ROWS + coord_base,
            $urandom_range(gsc_pkg::CLASS_MAX, 0), last);
  endfunction

  // Out-of-range coordinate: below the base (base 1 only) or past the edge
  function automatic int unsigned bad_coord(int unsigned span);
    if (coord_base && $urandom_range(1, 0) == 0) return 0;
    return $urandom_range(65535, coord_base + span);
  endfunction

  function automatic void add_broken_row(row_fault_e fault, logic last);
    int unsigned t, c, r, k;
    t = $urandom_range(TRAY_COUNT, 1);
    c = $urandom_range(coord_base + TRAY_COLS - 1, coord_base);
    r = $urandom_range(coord_base + TRAY_ROWS - 1, coord_base);
    k = $urandom_range(gsc_pkg::CLASS_MAX, 0);
    case (fault)
      BAD_CLASS: add_row(t, c, r, $urandom_range(255, gsc_pkg::CLASS_MAX + 1), last);
      BAD_TRAY: begin
        add_row($urandom_range(1, 0) ? 0 : $urandom_range(65535, TRAY_COUNT + 1),
                c, r, k, last);
      end
      BAD_COORD: begin
        if ($urandom_range(1, 0)) add_row(t, bad_coord(TRAY_COLS), r, k, last);
        else add_row(t, c, bad_coord(TRAY_ROWS), k, last);
      end
      default: add_row($urandom, $urandom, $urandom, $urandom, last);
    endcase
  endfunction

  // Sparse-style frame: mostly clean random slots, some repeats, some bad rows
  function automatic void add_sparse_frame(int unsigned len);
    int unsigned prev_slot, pick;
    logic        last;
    prev_slot = $urandom_range(SLOT_TOTAL - 1, 0);
    for (int unsigned i = 0; i < len; i++) begin
      last = (i == len - 1);
      pick = $urandom_range(99, 0);
      if (pick < 80) begin
        prev_slot = $urandom_range(SLOT_TOTAL - 1, 0);
        add_slot_row(prev_slot, last);
      end else if (pick < 88) begin
        add_slot_row(prev_slot, last);
      end else begin
        add_broken_row(row_fault_e'($urandom_range(BAD_NOISE, BAD_CLASS)), last);
      end
    end
  endfunction

  function automatic void add_sparse_run(int unsigned items);
    int unsigned stop;
    stop = queued_items + items;
    while (queued_items < stop) add_sparse_frame($urandom_range(16, 1));
  endfunction

  // Shuffled walk over the grid, cut or padded to the given row count; a
  // flawed frame may get one duplicated slot or one bad row at a random spot
  function automatic void add_grid_frame(int unsigned rows, logic flawed);
    int unsigned  order[$];
    int unsigned  j, tmp, p, n;
    frame_fault_e fault;
    for (int unsigned s = 0; s < SLOT_TOTAL; s++) order.push_back(s);
    for (int unsigned s = SLOT_TOTAL - 1; s > 0; s--) begin
      j = $urandom_range(s, 0);
      tmp = order[s];
      order[s] = order[j];
      order[j] = tmp;
    end
    while (order.size() > rows) void'(order.pop_back());
    while (order.size() < rows) order.push_back(order[$urandom_range(SLOT_TOTAL - 1, 0)]);
    n = order.size();
    p = $urandom_range(n - 1, 0);
    fault = flawed ? frame_fault_e'($urandom_range(FAULT_ROW, FAULT_NONE)) : FAULT_NONE;
    for (int unsigned i = 0; i < n; i++) begin
      if (i == p && fault == FAULT_DUP) add_slot_row(order[(i + 1) % n], i == n - 1);
      else if (i == p && fault == FAULT_ROW)
        add_broken_row(row_fault_e'($urandom_range(BAD_NOISE, BAD_CLASS)), i == n - 1);
      else add_slot_row(order[i], i == n - 1);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Sequence helpers
  // --------------------------------------------------------------------------
  // Config write; only called with the block drained
  task automatic set_reg(logic idx, logic val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == gsc_pkg::REG_FULL_MODE) full_grid_on = val;
    else coord_base = val;
  endtask

  // Sampled on the falling edge so the driver's pops at the rising edge are settled
  task automatic wait_idle();
    do @(negedge clk_i);
    while (rows_to_send.size() != 0 || s_axis_tvalid || frame_verdicts.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    idle_pct = 20;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed, sparse mode, base 1: one-row frames unless noted
    set_reg(gsc_pkg::REG_FULL_MODE, 1'b0);
    @(negedge clk_i);
    add_row(1, 1, 1, 0, 1);                  // lowest valid corner
    add_row(4, 8, 8, 2, 1);                  // highest valid corner, top class
    add_row(1, 1, 1, 3, 1);                  // class just past range
    add_row(1, 1, 1, 255, 1);                // class max
    add_row(0, 1, 1, 0, 1);                  // tray zero
    add_row(5, 1, 1, 1, 1);                  // tray just past range
    add_row(65535, 65535, 65535, 255, 1);    // everything bad: class wins
    add_row(65535, 1, 1, 0, 1);              // tray max
    add_row(0, 0, 0, 0, 1);                  // tray beats coordinate
    add_row(2, 0, 3, 0, 1);                  // column below base
    add_row(2, 9, 3, 0, 1);                  // column past edge
    add_row(2, 3, 0, 1, 1);                  // row below base
    add_row(2, 3, 65535, 1, 1);              // row max
    add_row(3, 4, 5, 0, 0);                  // same slot twice: duplicate
    add_row(3, 4, 5, 1, 1);
    add_row(3, 4, 5, 9, 0);                  // bad row claims no slot,
    add_row(3, 4, 5, 0, 0);                  // first error stays class
    add_row(3, 4, 5, 0, 1);
    wait_idle();

    // Base 0 corners, then random sparse frames
    set_reg(gsc_pkg::REG_COORD_BASE, 1'b0);
    @(negedge clk_i);
    add_row(1, 0, 0, 0, 1);
    add_row(1, 8, 0, 0, 1);
    add_row(4, 7, 7, 2, 1);
    add_row(1, 0, 8, 0, 1);
    add_sparse_run(120);
    wait_idle();

    // Full-grid mode, base 1: one randomly flawed grid and a few short frames
    set_reg(gsc_pkg::REG_FULL_MODE, 1'b1);
    set_reg(gsc_pkg::REG_COORD_BASE, 1'b1);
    @(negedge clk_i);
    idle_pct = 30;
    case ($urandom_range(3, 0))
      0: add_grid_frame(SLOT_TOTAL - 1, 1'b1);
      1: add_grid_frame(SLOT_TOTAL + 1, 1'b1);
      default: add_grid_frame(SLOT_TOTAL, 1'b1);
    endcase
    repeat (3) add_sparse_frame($urandom_range(10, 1));
    wait_idle();

    // Full-grid mode, base 0: a clean grid must pass
    set_reg(gsc_pkg::REG_COORD_BASE, 1'b0);
    @(negedge clk_i);
    idle_pct = 10;
    add_grid_frame(SLOT_TOTAL, 1'b0);
    wait_idle();

    // Sparse, base 1: rows_seen saturation, the largest sparse frame that
    // passes, random frames, then a frame left open across the next write
    set_reg(gsc_pkg::REG_FULL_MODE, 1'b0);
    set_reg(gsc_pkg::REG_COORD_BASE, 1'b1);
    @(negedge clk_i);
    idle_pct = 25;
    add_sparse_frame(520);
    add_grid_frame(SLOT_TOTAL - 1, 1'b0);
    add_sparse_run(60);
    repeat (3) add_slot_row($urandom_range(SLOT_TOTAL - 1, 0), 1'b0);
    wait_idle();

    // Open frame closes under full-grid mode: size fault
    set_reg(gsc_pkg::REG_FULL_MODE, 1'b1);
    @(negedge clk_i);
    add_slot_row($urandom_range(SLOT_TOTAL - 1, 0), 1'b1);
    wait_idle();

    // Closing stretch at full rate on both sides
    set_reg(gsc_pkg::REG_FULL_MODE, 1'b0);
    set_reg(gsc_pkg::REG_COORD_BASE, 1'b0);
    @(negedge clk_i);
    idle_pct = 0;
    add_sparse_run(100);
    wait_idle();

    if (mismatch_count == 0 && frame_verdicts.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
